// File: design/cagc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cagc_pkg: shared types and constants
// Field widths, register indexes, fixed-point formats and datapath commands.
// ----------------------------------------------------------------------------
package cagc_pkg;

  localparam int TARGET_W      = 15;
  localparam int GAIN_W        = 21;
  localparam int BIAS_FRAC     = 18;
  localparam int AVG_FRAC      = 16;
  localparam int GAIN_FRAC     = 16;
  localparam int CFG_IDX_W     = 4;
  localparam int CFG_DATA_W    = 21;
  // (target << 32) >= (avg << 21)  <=>  (target << 11) >= avg
  localparam int DIV_PRE_SHIFT = AVG_FRAC + GAIN_FRAC - GAIN_W;

  localparam int DEF_SAMPLE_WIDTH = 16;
  localparam int DEF_BIAS_SHIFT   = 18;
  localparam int DEF_AVG_SHIFT    = 16;

  localparam logic [TARGET_W-1:0]  TARGET_RESET   = 15'd8192;
  localparam logic [GAIN_W-1:0]    MAX_GAIN_RESET = 21'd1310720;
  localparam logic [GAIN_W-1:0]    UNITY_GAIN     = 21'd65536;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_GAIN   = 4'd1;

  // fraction bits of the corrected sample
  function automatic int mag_frac(int sw);
    return (31 - sw > BIAS_FRAC) ? BIAS_FRAC : 31 - sw;
  endfunction

  // width of the corrected sample
  function automatic int diff_w(int sw);
    return sw + 1 + mag_frac(sw);
  endfunction

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQ_I,
    OP_SQ_Q,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_AVG,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_GAIN,
    OP_MUL_I,
    OP_MUL_Q,
    OP_RES_Q
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   load_out;
  } dp_cmd_t;

endpackage

// File: design/cagc_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cagc_dpath: AGC datapath
// DC tracking, shared multiplier, iterative square root and divider, output
// rounding and saturation, configuration registers.
// ----------------------------------------------------------------------------
module cagc_dpath #(
  parameter int SAMPLE_WIDTH = cagc_pkg::DEF_SAMPLE_WIDTH,
  parameter int BIAS_SHIFT   = cagc_pkg::DEF_BIAS_SHIFT,
  parameter int AVG_SHIFT    = cagc_pkg::DEF_AVG_SHIFT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  cagc_pkg::dp_cmd_t                  cmd,
  input  logic signed [SAMPLE_WIDTH-1:0]     sample_i,
  input  logic signed [SAMPLE_WIDTH-1:0]     sample_q,
  input  logic                               cfg_we,
  input  logic [cagc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cagc_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic signed [SAMPLE_WIDTH-1:0]     out_i,
  output logic signed [SAMPLE_WIDTH-1:0]     out_q,
  output logic [cagc_pkg::GAIN_W-1:0]        gain_now
);
  import cagc_pkg::*;

  localparam int MF  = mag_frac(SAMPLE_WIDTH);
  localparam int BW  = SAMPLE_WIDTH + BIAS_FRAC;
  localparam int DW  = diff_w(SAMPLE_WIDTH);
  localparam int SQW = 2 * DW + 2;
  localparam int RW  = DW + 1;
  localparam int UP  = (MF < AVG_FRAC) ? AVG_FRAC - MF : 0;
  localparam int DN  = (MF > AVG_FRAC) ? MF - AVG_FRAC : 0;
  localparam int TW  = RW + UP;
  localparam int AW  = (SAMPLE_WIDTH + 17 > 31) ? SAMPLE_WIDTH + 17 : 31;
  localparam int RSH = MF + GAIN_FRAC;

  localparam logic signed [SQW:0] RND = (SQW + 1)'(1) << (RSH - 1);
  localparam logic signed [SQW:0] HI  = (SQW + 1)'((1 << (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [SQW:0] LO  = -HI - (SQW + 1)'(1);

  // configuration and state
  logic [TARGET_W-1:0]        target;
  logic [GAIN_W-1:0]          max_gain;
  logic signed [BW-1:0]       bias_i, bias_q;
  logic [AW-1:0]              avg;
  logic [GAIN_W-1:0]          gain;

  // working registers
  logic signed [DW-1:0]       di, dq;
  logic signed [SQW-1:0]      prod;
  logic [SQW-1:0]             acc;
  logic [SQW-1:0]             sq_v, sq_r, sq_b;
  logic [AW:0]                div_rem;
  logic                       div_sat;
  logic [GAIN_W-1:0]          quot;
  logic signed [SAMPLE_WIDTH-1:0] res_i, res_q;

  // combinational
  logic signed [BW-1:0]       si_w, sq_w;
  logic signed [BW:0]         bd_i, bd_q, ed_i, ed_q;
  logic signed [BW-1:0]       bias_i_next, bias_q_next;
  logic [DW-1:0]              abs_i, abs_q;
  logic signed [DW:0]         ma, mb;
  logic [SQW:0]               sq_t;
  logic [TW-1:0]              mag_t;
  logic [AW-1:0]              mag_s;
  logic signed [AW:0]         avg_diff;
  logic [AW-1:0]              avg_next;
  logic [AW:0]                tgt_ext;
  logic [AW+1:0]              rem_sh;

  function automatic logic signed [SAMPLE_WIDTH-1:0] round_sat(
    input logic signed [SQW-1:0] p
  );
    logic signed [SQW:0] pr;
    logic signed [SQW:0] rs;
    pr = (SQW + 1)'(p) + RND;
    rs = pr >>> RSH;
    if (rs > HI) begin
      rs = HI;
    end else if (rs < LO) begin
      rs = LO;
    end
    return SAMPLE_WIDTH'(rs);
  endfunction

  // DC bias update and corrected sample
  assign si_w        = {sample_i, BIAS_FRAC'(0)};
  assign sq_w        = {sample_q, BIAS_FRAC'(0)};
  assign bd_i        = (BW + 1)'(si_w) - (BW + 1)'(bias_i);
  assign bd_q        = (BW + 1)'(sq_w) - (BW + 1)'(bias_q);
  assign bias_i_next = BW'((BW + 1)'(bias_i) + (bd_i >>> BIAS_SHIFT));
  assign bias_q_next = BW'((BW + 1)'(bias_q) + (bd_q >>> BIAS_SHIFT));
  assign ed_i        = (BW + 1)'(si_w) - (BW + 1)'(bias_i_next);
  assign ed_q        = (BW + 1)'(sq_w) - (BW + 1)'(bias_q_next);

  assign abs_i = di[DW-1] ? DW'(-di) : DW'(di);
  assign abs_q = dq[DW-1] ? DW'(-dq) : DW'(dq);

  // shared multiplier operands
  always_comb begin
    unique case (cmd.op)
      OP_SQ_I: begin
        ma = {1'b0, abs_i};
        mb = {1'b0, abs_i};
      end
      OP_SQ_Q: begin
        ma = {1'b0, abs_q};
        mb = {1'b0, abs_q};
      end
      OP_MUL_Q: begin
        ma = (DW + 1)'(dq);
        mb = (DW + 1)'(gain);
      end
      default: begin
        ma = (DW + 1)'(di);
        mb = (DW + 1)'(gain);
      end
    endcase
  end

  // square root, magnitude rescale, average update
  assign sq_t     = {1'b0, sq_r} + {1'b0, sq_b};
  assign mag_t    = TW'(sq_r[RW-1:0]) << UP;
  assign mag_s    = AW'(mag_t >> DN);
  assign avg_diff = $signed({1'b0, mag_s}) - $signed({1'b0, avg});
  assign avg_next = AW'($signed({1'b0, avg}) + (avg_diff >>> AVG_SHIFT));

  // divider
  assign tgt_ext = (AW + 1)'({target, DIV_PRE_SHIFT'(0)});
  assign rem_sh  = {div_rem, 1'b0};

  // state with reset
  always_ff @(posedge clk) begin
    if (rst) begin
      target   <= TARGET_RESET;
      max_gain <= MAX_GAIN_RESET;
      avg      <= AW'({TARGET_RESET, AVG_FRAC'(0)});
      bias_i   <= '0;
      bias_q   <= '0;
      gain     <= UNITY_GAIN;
    end else begin
      if (cfg_we && cfg_index == REG_TARGET) begin
        target <= cfg_data[TARGET_W-1:0];
        avg    <= AW'({cfg_data[TARGET_W-1:0], AVG_FRAC'(0)});
      end else if (cmd.op == OP_AVG) begin
        avg <= avg_next;
      end
      if (cfg_we && cfg_index == REG_MAX_GAIN) begin
        max_gain <= cfg_data[GAIN_W-1:0];
      end
      if (cmd.op == OP_LOAD) begin
        bias_i <= bias_i_next;
        bias_q <= bias_q_next;
      end
      if (cmd.op == OP_GAIN) begin
        gain <= (div_sat || quot > max_gain) ? max_gain : quot;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    prod <= ma * mb;
    unique case (cmd.op)
      OP_LOAD: begin
        di <= DW'(ed_i >>> (BIAS_FRAC - MF));
        dq <= DW'(ed_q >>> (BIAS_FRAC - MF));
      end
      OP_SQ_Q: begin
        acc <= unsigned'(prod);
      end
      OP_SQRT_INIT: begin
        sq_v <= acc + unsigned'(prod);
        sq_r <= '0;
        sq_b <= SQW'(1) << (SQW - 2);
      end
      OP_SQRT_STEP: begin
        if ({1'b0, sq_v} >= sq_t) begin
          sq_v <= sq_v - SQW'(sq_t);
          sq_r <= (sq_r >> 1) + sq_b;
        end else begin
          sq_r <= sq_r >> 1;
        end
        sq_b <= sq_b >> 2;
      end
      OP_DIV_INIT: begin
        div_sat <= tgt_ext >= {1'b0, avg};
        div_rem <= tgt_ext;
        quot    <= '0;
      end
      OP_DIV_STEP: begin
        if (rem_sh >= (AW + 2)'(avg)) begin
          div_rem <= (AW + 1)'(rem_sh - (AW + 2)'(avg));
          quot    <= {quot[GAIN_W-2:0], 1'b1};
        end else begin
          div_rem <= (AW + 1)'(rem_sh);
          quot    <= {quot[GAIN_W-2:0], 1'b0};
        end
      end
      OP_MUL_Q: begin
        res_i <= round_sat(prod);
      end
      OP_RES_Q: begin
        res_q <= round_sat(prod);
      end
      default: begin
      end
    endcase
    if (cmd.load_out) begin
      out_i    <= res_i;
      out_q    <= res_q;
      gain_now <= gain;
    end
  end

  a_gain_clamped: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_GAIN |=> gain <= max_gain)
    else $error("gain above ceiling");

  a_div_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_DIV_STEP && !div_sat) |-> div_rem < {1'b0, avg})
    else $error("divider remainder out of range");

endmodule

// File: design/cagc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cagc_ctrl: AGC sequencer
// Steps the datapath through one item and hands the result to the output
// register.
// ----------------------------------------------------------------------------
module cagc_ctrl #(
  parameter int SAMPLE_WIDTH = cagc_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output cagc_pkg::dp_cmd_t cmd
);
  import cagc_pkg::*;

  localparam int SQRT_STEPS = diff_w(SAMPLE_WIDTH) + 1;
  localparam int DIV_STEPS  = GAIN_W;
  localparam int MAX_STEPS  = (SQRT_STEPS > DIV_STEPS) ? SQRT_STEPS : DIV_STEPS;
  localparam int CNT_W      = $clog2(MAX_STEPS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ_I,
    S_SQ_Q,
    S_SQRT_INIT,
    S_SQRT,
    S_AVG,
    S_DIV_INIT,
    S_DIV,
    S_GAIN,
    S_MUL_I,
    S_MUL_Q,
    S_RES_Q,
    S_EMIT
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   cnt;
  logic               emit;

  assign in_ready     = (state == S_IDLE);
  assign emit         = (state == S_EMIT) && (!out_valid || out_ready);

  always_comb begin
    cmd.load_out = emit;
    unique case (state)
      S_IDLE:      cmd.op = in_valid ? OP_LOAD : OP_NONE;
      S_SQ_I:      cmd.op = OP_SQ_I;
      S_SQ_Q:      cmd.op = OP_SQ_Q;
      S_SQRT_INIT: cmd.op = OP_SQRT_INIT;
      S_SQRT:      cmd.op = OP_SQRT_STEP;
      S_AVG:       cmd.op = OP_AVG;
      S_DIV_INIT:  cmd.op = OP_DIV_INIT;
      S_DIV:       cmd.op = OP_DIV_STEP;
      S_GAIN:      cmd.op = OP_GAIN;
      S_MUL_I:     cmd.op = OP_MUL_I;
      S_MUL_Q:     cmd.op = OP_MUL_Q;
      S_RES_Q:     cmd.op = OP_RES_Q;
      default:     cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_SQ_I;
          end
        end
        S_SQ_I:      state <= S_SQ_Q;
        S_SQ_Q:      state <= S_SQRT_INIT;
        S_SQRT_INIT: begin
          cnt   <= '0;
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (cnt == CNT_W'(SQRT_STEPS - 1)) begin
            state <= S_AVG;
          end
          cnt <= cnt + 1'b1;
        end
        S_AVG:       state <= S_DIV_INIT;
        S_DIV_INIT: begin
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (cnt == CNT_W'(DIV_STEPS - 1)) begin
            state <= S_GAIN;
          end
          cnt <= cnt + 1'b1;
        end
        S_GAIN:      state <= S_MUL_I;
        S_MUL_I:     state <= S_MUL_Q;
        S_MUL_Q:     state <= S_RES_Q;
        S_RES_Q:     state <= S_EMIT;
        S_EMIT: begin
          if (emit) begin
            state <= S_IDLE;
          end
        end
        default:     state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item accepted while busy");

  a_sqrt_count: assert property (@(posedge clk) disable iff (rst)
    state == S_SQRT |-> cnt < CNT_W'(SQRT_STEPS))
    else $error("square root step count overrun");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> cnt < CNT_W'(DIV_STEPS))
    else $error("divider step count overrun");

  a_emit_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_valid && !out_ready) |=> state == S_EMIT)
    else $error("result overwrote an untaken item");

endmodule

// File: design/complex_agc_with_dc_removal.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_agc_with_dc_removal: complex AGC with DC removal
// I/Q DC blocker followed by a magnitude-tracking automatic gain control.
// ----------------------------------------------------------------------------
// Each input item is one signed I/Q sample; each yields one output item with
// the DC-corrected sample scaled by the current gain (rounded, saturated) and
// the gain used, in Q5.16. The magnitude square root runs one bit pair per
// cycle (corrected-sample width plus one steps, i.e. 33 at 16 bits), the gain
// divider one quotient bit per cycle (21 steps), and the remaining states go
// to loading, sequencing and the shared-multiplier passes.
// Only one item is in flight, but a finished result sits in the output
// register, so the next item is taken while it waits.
// Writing target_level (index 0) reloads the magnitude average; max_gain is
// index 1; other indexes are ignored. Write configuration only while idle.
// ----------------------------------------------------------------------------
module complex_agc_with_dc_removal #(
  parameter int SAMPLE_WIDTH = cagc_pkg::DEF_SAMPLE_WIDTH,
  parameter int BIAS_SHIFT   = cagc_pkg::DEF_BIAS_SHIFT,
  parameter int AVG_SHIFT    = cagc_pkg::DEF_AVG_SHIFT
) (
  input  logic                            clk,
  input  logic                            rst,
  // input items
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]  sample_i,
  input  logic signed [SAMPLE_WIDTH-1:0]  sample_q,
  // output items
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]  out_i,
  output logic signed [SAMPLE_WIDTH-1:0]  out_q,
  output logic [cagc_pkg::GAIN_W-1:0]     gain_now,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cagc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cagc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cagc_pkg::*;

  dp_cmd_t cmd;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  // sequencer: one state per datapath step, counted loops for the
  // square root and the divider
  cagc_ctrl #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // datapath: bias tracking, one shared multiplier, the iterative units
  // and the output register
  cagc_dpath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .BIAS_SHIFT   (BIAS_SHIFT),
    .AVG_SHIFT    (AVG_SHIFT)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sample_i  (sample_i),
    .sample_q  (sample_q),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_i     (out_i),
    .out_q     (out_q),
    .gain_now  (gain_now)
  );

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: complex AGC with DC removal
// Drives I/Q samples through the block under bursty input and a stalling
// output, predicts every output item with a bit-exact software copy of the
// DC blocker, magnitude tracker and gain divider, and compares field by field
// across several target and gain-ceiling settings.
// ----------------------------------------------------------------------------
module testbench;
  import cagc_pkg::*;

  localparam int SW = DEF_SAMPLE_WIDTH;
  // an index past the register list; writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'd9;
  // margin for draining after the last result is taken
  localparam int DRAIN_CYCLES = 150;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES = 600;
  localparam int ITEMS_PER_PHASE = 255;
  localparam int NUM_PHASES = 6;

  typedef struct {
    logic signed [SW-1:0] oi;
    logic signed [SW-1:0] oq;
    logic [GAIN_W-1:0]    gain;
  } agc_out_t;

  // directed row: sample, and an expected result where it is obvious
  typedef struct {
    logic signed [SW-1:0] si;
    logic signed [SW-1:0] sq;
    bit                   typed;
    logic signed [SW-1:0] ei;
    logic signed [SW-1:0] eq;
    logic [GAIN_W-1:0]    eg;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SW-1:0] sample_i = '0;
  logic signed [SW-1:0] sample_q = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SW-1:0] out_i;
  logic signed [SW-1:0] out_q;
  logic [GAIN_W-1:0] gain_now;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  complex_agc_with_dc_removal u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .sample_i(sample_i), .sample_q(sample_q),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_i(out_i), .out_q(out_q), .gain_now(gain_now),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --- predictor state: mirrors the block's registers and accumulators ---
  logic [TARGET_W-1:0] tgt_level = TARGET_RESET;
  logic [GAIN_W-1:0]   gain_ceiling = MAX_GAIN_RESET;
  longint              bias_i = 0;       // 18 fraction bits
  longint              bias_q = 0;
  longint              mag_avg = longint'(TARGET_RESET) <<< AVG_FRAC;

  agc_out_t pending_out[$];
  int       mismatches = 0;
  bit       hold_req = 1'b0;
  int       idle_cycles = 0;

  // directed items: extremes, sign corners, alternating bit patterns.
  // The first row follows reset: zero sample, the average decays by one
  // step, so the gain is 2^32 / 65535 = 65537 and the output is zero.
  dir_row_t dir_rows [0:15] = '{
    '{16'sd0,      16'sd0,      1'b1, 16'sd0, 16'sd0, 21'd65537},
    '{16'sd32767,  16'sd32767,  1'b0, '0, '0, '0},
    '{-16'sd32768, -16'sd32768, 1'b0, '0, '0, '0},
    '{16'sd32767,  -16'sd32768, 1'b0, '0, '0, '0},
    '{-16'sd32768, 16'sd32767,  1'b0, '0, '0, '0},
    '{16'sd1,      -16'sd1,     1'b0, '0, '0, '0},
    '{-16'sd1,     16'sd1,      1'b0, '0, '0, '0},
    '{16'sd0,      16'sd32767,  1'b0, '0, '0, '0},
    '{16'sd0,      -16'sd32768, 1'b0, '0, '0, '0},
    '{16'sh5555,   16'shAAAA,   1'b0, '0, '0, '0},
    '{16'shAAAA,   16'sh5555,   1'b0, '0, '0, '0},
    '{16'sd12345,  -16'sd12345, 1'b0, '0, '0, '0},
    '{16'sd0,      16'sd0,      1'b0, '0, '0, '0},
    '{16'sd3,      16'sd4,      1'b0, '0, '0, '0},
    '{-16'sd32768, 16'sd0,      1'b0, '0, '0, '0},
    '{16'sd32767,  16'sd0,      1'b0, '0, '0, '0}
  };

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r = 0;
    longint unsigned b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // product rounded half up, then clipped to the sample range
  function automatic logic signed [SW-1:0] scale_sat(longint d, logic [GAIN_W-1:0] g);
    longint p;
    longint r;
    p = d * longint'(g);
    r = (p + (longint'(1) <<< 30)) >>> 31;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[SW-1:0];
  endfunction

  // one sample through the DC blocker, magnitude average and gain divider
  function automatic agc_out_t agc_step(logic signed [SW-1:0] s_i, logic signed [SW-1:0] s_q);
    agc_out_t res;
    longint si;
    longint sq;
    longint di;
    longint dq;
    longint unsigned ai;
    longint unsigned aq;
    longint unsigned mag;
    longint g;
    si = longint'(s_i) <<< BIAS_FRAC;
    sq = longint'(s_q) <<< BIAS_FRAC;
    bias_i += (si - bias_i) >>> DEF_BIAS_SHIFT;
    bias_q += (sq - bias_q) >>> DEF_BIAS_SHIFT;
    di = (si - bias_i) >>> 3;
    dq = (sq - bias_q) >>> 3;
    ai = (di < 0) ? -di : di;
    aq = (dq < 0) ? -dq : dq;
    mag = int_sqrt(ai * ai + aq * aq) << 1;
    mag_avg += (longint'(mag) - mag_avg) >>> DEF_AVG_SHIFT;
    if (mag_avg <= 0) begin
      g = gain_ceiling;
    end else begin
      g = (longint'(tgt_level) <<< 32) / mag_avg;
      if (g > longint'(gain_ceiling)) g = gain_ceiling;
    end
    res.gain = g[GAIN_W-1:0];
    res.oi = scale_sat(di, res.gain);
    res.oq = scale_sat(dq, res.gain);
    return res;
  endfunction

  // offer one item and stay high until taken; returns on the accepting edge
  task automatic send_sample(logic signed [SW-1:0] s_i, logic signed [SW-1:0] s_q,
                             bit typed, agc_out_t typed_res);
    agc_out_t res;
    in_valid <= 1'b1;
    sample_i <= s_i;
    sample_q <= s_q;
    do @(posedge clk); while (!in_ready);
    res = agc_step(s_i, s_q);
    pending_out.push_back(typed ? typed_res : res);
  endtask

  // random gap between bursts; lowers valid only when a gap is taken
  task automatic maybe_gap();
    int gap;
    if ($urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 90);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering, let every result drain, then allow the block to settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_out.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one write, then an idle gap so back-to-back writes never collide
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_TARGET) begin
      tgt_level = data[TARGET_W-1:0];
      mag_avg = longint'(tgt_level) <<< AVG_FRAC;
    end else if (idx == REG_MAX_GAIN) begin
      gain_ceiling = data[GAIN_W-1:0];
    end
    @(posedge clk);
  endtask

  // random sample: mostly realistic signals (DC offset plus noise, scaled
  // bursts) with full-range noise and corner values mixed in
  function automatic logic signed [SW-1:0] rand_sample(int dc, int amp);
    int v;
    case ($urandom_range(0, 9))
      0, 1:    v = $signed($urandom_range(0, 65535)) - 32768;
      2, 3, 4: v = dc + $signed($urandom_range(0, 2 * amp)) - amp;
      5, 6:    v = $signed($urandom_range(0, 2 * amp)) - amp;
      7:       v = $signed($urandom_range(0, 512)) - 256;
      8:       v = $urandom_range(0, 1) ? 32767 : -32768;
      default: v = dc;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[SW-1:0];
  endfunction

  // --- stimulus ---
  initial begin
    agc_out_t typed_res;
    int dc_i;
    int dc_q;
    int amp;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[k]) begin
      typed_res.oi = dir_rows[k].ei;
      typed_res.oq = dir_rows[k].eq;
      typed_res.gain = dir_rows[k].eg;
      send_sample(dir_rows[k].si, dir_rows[k].sq, dir_rows[k].typed, typed_res);
      maybe_gap();
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      // each phase moves to a new setting; extremes included
      case (p)
        0: begin
          write_reg(REG_TARGET, 21'd32767);
          write_reg(REG_MAX_GAIN, 21'd2097151);
        end
        1: begin
          write_reg(REG_TARGET, 21'd1);
          write_reg(REG_MAX_GAIN, 21'd65536);
        end
        2: begin
          // target of zero: the gain drops to zero once the average is above zero
          write_reg(REG_TARGET, 21'd0);
          write_reg(REG_MAX_GAIN, 21'd1310720);
        end
        3: begin
          // high bits above the target width are dropped
          write_reg(REG_TARGET, 21'h1F8000 | 21'd4000);
          write_reg(REG_SPARE, 21'h1FFFFF);
        end
        4: begin
          write_reg(REG_TARGET, 21'd16384);
          write_reg(REG_MAX_GAIN, 21'd300000);
        end
        default: begin
          write_reg(REG_TARGET, {6'd0, TARGET_RESET});
          write_reg(REG_MAX_GAIN, MAX_GAIN_RESET);
        end
      endcase
      dc_i = $signed($urandom_range(0, 16000)) - 8000;
      dc_q = $signed($urandom_range(0, 16000)) - 8000;
      amp = $urandom_range(1, 4) == 1 ? $urandom_range(1, 200) : $urandom_range(200, 20000);
      if (p == 2) hold_req = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_sample(rand_sample(dc_i, amp), rand_sample(dc_q, amp), 1'b0, typed_res);
        if (n % 60 == 59) amp = $urandom_range(1, 25000);
        maybe_gap();
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("complex_agc_with_dc_removal: match");
    end else begin
      $display("complex_agc_with_dc_removal: mismatch");
    end
    $finish;
  end

  // --- output side: stall pattern, one long hold-off, and checking ---
  int rx_cycle = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    agc_out_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_out.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected item: out_i=%0d out_q=%0d gain=%0d", out_i, out_q, gain_now);
        end else begin
          want = pending_out.pop_front();
          if (out_i !== want.oi || out_q !== want.oq || gain_now !== want.gain) begin
            mismatches++;
            if (mismatches <= 10)
              $display("item differs: exp i=%0d q=%0d g=%0d got i=%0d q=%0d g=%0d",
                       want.oi, want.oq, want.gain, out_i, out_q, gain_now);
          end
        end
      end
      rx_cycle++;
      // long hold-off once, so the block backs up and blocks its input
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case ((rx_cycle / 700) % 4)
          0: out_ready <= 1'b1;
          1: out_ready <= $urandom_range(0, 1);
          2: out_ready <= (rx_cycle % 5) == 0;
          default: out_ready <= $urandom_range(0, 7) != 0;
        endcase
      end
    end
  end

  // watchdog: too long with no handshake on any channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("complex_agc_with_dc_removal: mismatch");
        $finish;
      end
    end
  end

endmodule
